// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/stbl_pkg.sv -----
// ----------------------------------------------------------------------------
// stbl_pkg
// Types, codes and constants of the soft timer bank and LED blinker.
// ----------------------------------------------------------------------------
package stbl_pkg;

  localparam int NumTimers = 8;
  localparam int Prescale  = 10;
  localparam logic [3:0] PrescaleLoad = 4'(Prescale);

  typedef logic [15:0] count_word_t;
  typedef logic [1:0]  req_t;
  typedef logic [2:0]  tid_t;
  typedef logic [2:0]  alarm_t;
  typedef logic [1:0]  phase_t;
  typedef logic [1:0]  cfg_idx_t;

  // Request codes
  localparam req_t ReqTick  = 2'd0;
  localparam req_t ReqArm   = 2'd1;
  localparam req_t ReqClear = 2'd2;
  localparam req_t ReqRead  = 2'd3;

  // Timer identifiers
  localparam tid_t TAdc = 3'd0;
  localparam tid_t TTmo = 3'd1;
  localparam tid_t TSta = 3'd2;
  localparam tid_t TWar = 3'd3;
  localparam tid_t TFlt = 3'd4;
  localparam tid_t TBit = 3'd5;
  localparam tid_t TTmp = 3'd6;
  localparam tid_t TDrf = 3'd7;

  // Alarm codes
  localparam alarm_t AlarmNone     = 3'd0;
  localparam alarm_t AlarmPower    = 3'd1;
  localparam alarm_t AlarmSelfTest = 3'd2;
  localparam alarm_t AlarmEeprom   = 3'd3;
  localparam alarm_t AlarmIrOffset = 3'd4;

  // Slot phases
  localparam phase_t PhaseRefresh = 2'd0;
  localparam phase_t PhaseBlink   = 2'd1;
  localparam phase_t PhaseFault   = 2'd2;
  localparam phase_t PhasePeriod  = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t CfgSelfTestAuto = 2'd0;
  localparam cfg_idx_t CfgWarmUp       = 2'd1;
  localparam cfg_idx_t CfgStartCount   = 2'd2;

  // Configuration reset values
  localparam logic        SelfTestAutoRst = 1'b1;
  localparam logic [14:0] WarmUpRst       = 15'd300;
  localparam logic [15:0] StartCountRst   = 16'd0;

  // Count words: bit 15 runs the timer, bits 14..0 hold the count
  localparam count_word_t Run       = 16'h8000;
  localparam count_word_t AdcReload = 16'h8003;
  localparam count_word_t StaReload = 16'h804A;
  localparam count_word_t StaOff    = 16'h803E;
  localparam count_word_t WarReload = 16'h8004;
  localparam count_word_t FltReload = 16'h804A;
  localparam count_word_t FltHit0   = 16'h8000;
  localparam count_word_t FltHit1   = 16'h800A;
  localparam count_word_t FltHit2   = 16'h8014;
  localparam count_word_t FltHit3   = 16'h801E;
  localparam count_word_t BitReload = 16'h85DB;
  localparam count_word_t TmpReload = 16'h8018;
  localparam count_word_t DrfReset  = 16'h8018;
  localparam count_word_t DrfReload = 16'h807C;

  typedef struct packed {
    req_t        req;
    tid_t        id;
    logic        en;
    logic [14:0] cnt;
    alarm_t      alarm;
  } req_word_t;

  typedef struct packed {
    count_word_t cnt;
    logic        fire;
  } cd_t;

  // One step of a running timer: reload and fire on expiry, else decrement
  function automatic cd_t count_down(count_word_t c, count_word_t reload);
    cd_t r;
    r.cnt  = c;
    r.fire = 1'b0;
    if (c[15]) begin
      if (c == Run) begin
        r.cnt  = reload;
        r.fire = 1'b1;
      end else begin
        r.cnt = c - 16'd1;
      end
    end
    return r;
  endfunction

  // Self-test count word after warm-up load
  function automatic count_word_t self_test_load(logic auto_start, logic [14:0] warm);
    count_word_t r;
    r = '0;
    if (auto_start) begin
      r = 16'(Run + {1'b0, warm} - 16'd1);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/soft_timer_bank_led_blinker.sv -----
// An accepted word is held in the request register; its result goes to the result register.
// Throughput: one request word per cycle while req_stall is low; an empty request
// register takes a new word while a finished result waits. Timers update from one
// register stage: base timers on each tick, slot timers on a reload in their phase.
// Reset (rst, synchronous): timers, flags, prescaler, slot phase and
// configuration take their defaults at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// soft_timer_bank_led_blinker
// Eight soft timers on a base tick with a prescaled four-phase slot
// sequencer driving LED refresh, blink, toggle, fault flash and period timers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module soft_timer_bank_led_blinker (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  timer_id,
  input  logic        arm_enable,
  input  logic [14:0] arm_count,
  input  logic [2:0]  alarm_state,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        adc_due,
  output logic        timeout_flag,
  output logic        led_refresh_pulse,
  output logic        status_led_on,
  output logic        warning_led_on,
  output logic        fault_flash_flag,
  output logic [15:0] self_test_periods,
  output logic        temp_calc_due,
  output logic        drift_check_due,
  output logic [14:0] timer_value,
  output logic        timer_running,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  stbl_pkg::req_word_t   s1;
  logic                  s1_valid;
  logic                  advance;
  logic                  process;

  stbl_pkg::count_word_t counts      [stbl_pkg::NumTimers];
  stbl_pkg::count_word_t counts_next [stbl_pkg::NumTimers];

  logic adc_flag, tmo_flag, sta_flag, war_flag, flt_flag, tmp_flag, drf_flag;
  logic adc_flag_next, tmo_flag_next, sta_flag_next, war_flag_next;
  logic flt_flag_next, tmp_flag_next, drf_flag_next;
  logic [15:0] periods, periods_next;

  logic [3:0]           prescale_count, prescale_next;
  stbl_pkg::phase_t     slot_phase, slot_next;

  logic        self_test_auto, self_test_auto_next;
  logic [14:0] warm_up_slots, warm_up_slots_next;
  logic [15:0] start_count, start_count_next;

  logic        pulse;
  logic [14:0] tval;
  logic        trun;

  logic        presc_ok;
  logic        presc_full;
  logic        refresh_tick;

  stbl_pkg::cd_t cd_adc, cd_tmo, cd_sta, cd_war, cd_flt, cd_bit, cd_tmp, cd_drf;

  // Move a word forward when the result register is free or being taken
  assign advance   = !rsp_valid || !rsp_stall;
  assign process   = s1_valid && advance;
  assign req_stall = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  // Single timer steps, taken from the current counts
  always_comb begin
    cd_adc = stbl_pkg::count_down(counts[stbl_pkg::TAdc], stbl_pkg::AdcReload);
    cd_tmo = stbl_pkg::count_down(counts[stbl_pkg::TTmo], '0);
    cd_sta = stbl_pkg::count_down(counts[stbl_pkg::TSta], stbl_pkg::StaReload);
    cd_war = stbl_pkg::count_down(counts[stbl_pkg::TWar], stbl_pkg::WarReload);
    cd_flt = stbl_pkg::count_down(counts[stbl_pkg::TFlt], stbl_pkg::FltReload);
    cd_bit = stbl_pkg::count_down(counts[stbl_pkg::TBit], stbl_pkg::BitReload);
    cd_tmp = stbl_pkg::count_down(counts[stbl_pkg::TTmp], stbl_pkg::TmpReload);
    cd_drf = stbl_pkg::count_down(counts[stbl_pkg::TDrf], stbl_pkg::DrfReload);
  end

  // Apply one request word and any configuration write
  always_comb begin
    logic [3:0] presc_dec;
    logic       hit;
    counts_next         = counts;
    adc_flag_next       = adc_flag;
    tmo_flag_next       = tmo_flag;
    sta_flag_next       = sta_flag;
    war_flag_next       = war_flag;
    flt_flag_next       = flt_flag;
    tmp_flag_next       = tmp_flag;
    drf_flag_next       = drf_flag;
    periods_next        = periods;
    prescale_next       = prescale_count;
    slot_next           = slot_phase;
    self_test_auto_next = self_test_auto;
    warm_up_slots_next  = warm_up_slots;
    start_count_next    = start_count;
    pulse               = 1'b0;
    tval                = '0;
    trun                = 1'b0;
    presc_dec           = prescale_count - 4'd1;
    hit                 = 1'b0;

    if (process) begin
      unique case (s1.req)
        stbl_pkg::ReqTick: begin
          // base-rate timers
          counts_next[stbl_pkg::TAdc] = cd_adc.cnt;
          if (cd_adc.fire) adc_flag_next = 1'b1;
          counts_next[stbl_pkg::TTmo] = cd_tmo.cnt;
          if (cd_tmo.fire) tmo_flag_next = 1'b1;
          // prescaler and slot sequencer
          if (presc_dec != 4'd0) begin
            prescale_next = presc_dec;
          end else begin
            prescale_next = stbl_pkg::PrescaleLoad;
            slot_next     = slot_phase + 2'd1;
            case (slot_phase)
              stbl_pkg::PhaseRefresh: begin
                pulse = 1'b1;
              end
              stbl_pkg::PhaseBlink: begin
                counts_next[stbl_pkg::TSta] = cd_sta.cnt;
                if (cd_sta.fire) begin
                  sta_flag_next = 1'b1;
                end else if (counts[stbl_pkg::TSta] == stbl_pkg::StaOff) begin
                  sta_flag_next = 1'b0;
                end
                counts_next[stbl_pkg::TWar] = cd_war.cnt;
                if (cd_war.fire) war_flag_next = !war_flag;
              end
              stbl_pkg::PhaseFault: begin
                counts_next[stbl_pkg::TFlt] = cd_flt.cnt;
                case (s1.alarm)
                  stbl_pkg::AlarmPower:
                    hit = (cd_flt.cnt == stbl_pkg::FltHit0);
                  stbl_pkg::AlarmSelfTest:
                    hit = (cd_flt.cnt == stbl_pkg::FltHit0) ||
                          (cd_flt.cnt == stbl_pkg::FltHit1);
                  stbl_pkg::AlarmEeprom:
                    hit = (cd_flt.cnt == stbl_pkg::FltHit0) ||
                          (cd_flt.cnt == stbl_pkg::FltHit1) ||
                          (cd_flt.cnt == stbl_pkg::FltHit2);
                  stbl_pkg::AlarmIrOffset:
                    hit = (cd_flt.cnt == stbl_pkg::FltHit0) ||
                          (cd_flt.cnt == stbl_pkg::FltHit1) ||
                          (cd_flt.cnt == stbl_pkg::FltHit2) ||
                          (cd_flt.cnt == stbl_pkg::FltHit3);
                  default:
                    hit = 1'b0;
                endcase
                if (hit) flt_flag_next = 1'b1;
              end
              default: begin
                counts_next[stbl_pkg::TBit] = cd_bit.cnt;
                if (cd_bit.fire) periods_next = periods + 16'd1;
                counts_next[stbl_pkg::TTmp] = cd_tmp.cnt;
                if (cd_tmp.fire) tmp_flag_next = 1'b1;
                counts_next[stbl_pkg::TDrf] = cd_drf.cnt;
                if (cd_drf.fire) drf_flag_next = 1'b1;
              end
            endcase
          end
        end
        stbl_pkg::ReqArm: begin
          counts_next[s1.id] = {s1.en, s1.cnt};
        end
        stbl_pkg::ReqClear: begin
          unique case (s1.id)
            stbl_pkg::TAdc: adc_flag_next = 1'b0;
            stbl_pkg::TTmo: tmo_flag_next = 1'b0;
            stbl_pkg::TSta: sta_flag_next = 1'b0;
            stbl_pkg::TWar: war_flag_next = 1'b0;
            stbl_pkg::TFlt: flt_flag_next = 1'b0;
            stbl_pkg::TBit: periods_next  = '0;
            stbl_pkg::TTmp: tmp_flag_next = 1'b0;
            stbl_pkg::TDrf: drf_flag_next = 1'b0;
          endcase
        end
        stbl_pkg::ReqRead: begin
          tval = counts[s1.id][14:0];
          trun = counts[s1.id][15];
        end
      endcase
    end

    // Configuration write to a defined index reloads the self-test timer and its period count
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stbl_pkg::CfgSelfTestAuto: self_test_auto_next = cfg_data[0];
        stbl_pkg::CfgWarmUp:       warm_up_slots_next  = cfg_data[14:0];
        stbl_pkg::CfgStartCount:   start_count_next    = cfg_data;
        default: ;
      endcase
      if ((cfg_index == stbl_pkg::CfgSelfTestAuto) ||
          (cfg_index == stbl_pkg::CfgWarmUp) ||
          (cfg_index == stbl_pkg::CfgStartCount)) begin
        counts_next[stbl_pkg::TBit] =
          stbl_pkg::self_test_load(self_test_auto_next, warm_up_slots_next);
        periods_next = self_test_auto_next ? start_count_next : 16'd0;
      end
    end
  end

  // Timer state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      self_test_auto <= stbl_pkg::SelfTestAutoRst;
      warm_up_slots  <= stbl_pkg::WarmUpRst;
      start_count    <= stbl_pkg::StartCountRst;
      counts[stbl_pkg::TAdc] <= stbl_pkg::AdcReload;
      counts[stbl_pkg::TTmo] <= '0;
      counts[stbl_pkg::TSta] <= '0;
      counts[stbl_pkg::TWar] <= '0;
      counts[stbl_pkg::TFlt] <= '0;
      counts[stbl_pkg::TBit] <=
        stbl_pkg::self_test_load(stbl_pkg::SelfTestAutoRst, stbl_pkg::WarmUpRst);
      counts[stbl_pkg::TTmp] <= stbl_pkg::TmpReload;
      counts[stbl_pkg::TDrf] <= stbl_pkg::DrfReset;
      adc_flag       <= 1'b0;
      tmo_flag       <= 1'b0;
      sta_flag       <= 1'b0;
      war_flag       <= 1'b0;
      flt_flag       <= 1'b0;
      tmp_flag       <= 1'b0;
      drf_flag       <= 1'b1;
      periods        <= stbl_pkg::SelfTestAutoRst ? stbl_pkg::StartCountRst : 16'd0;
      prescale_count <= stbl_pkg::PrescaleLoad;
      slot_phase     <= stbl_pkg::PhaseRefresh;
    end else begin
      self_test_auto <= self_test_auto_next;
      warm_up_slots  <= warm_up_slots_next;
      start_count    <= start_count_next;
      counts         <= counts_next;
      adc_flag       <= adc_flag_next;
      tmo_flag       <= tmo_flag_next;
      sta_flag       <= sta_flag_next;
      war_flag       <= war_flag_next;
      flt_flag       <= flt_flag_next;
      tmp_flag       <= tmp_flag_next;
      drf_flag       <= drf_flag_next;
      periods        <= periods_next;
      prescale_count <= prescale_next;
      slot_phase     <= slot_next;
    end
  end

  // Request register: take a new word whenever not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1.req   <= req_type;
      s1.id    <= timer_id;
      s1.en    <= arm_enable;
      s1.cnt   <= arm_count;
      s1.alarm <= alarm_state;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      adc_due           <= adc_flag_next;
      timeout_flag      <= tmo_flag_next;
      led_refresh_pulse <= pulse;
      status_led_on     <= sta_flag_next;
      warning_led_on    <= war_flag_next;
      fault_flash_flag  <= flt_flag_next;
      self_test_periods <= periods_next;
      temp_calc_due     <= tmp_flag_next;
      drift_check_due   <= drf_flag_next;
      timer_value       <= tval;
      timer_running     <= trun;
    end
  end

  // Prescaler range, reload mark and the tick that ends a refresh slot
  assign presc_ok     = (prescale_count != 4'd0) &&
                        (prescale_count <= stbl_pkg::PrescaleLoad);
  assign presc_full   = (prescale_count == stbl_pkg::PrescaleLoad);
  assign refresh_tick = process && (s1.req == stbl_pkg::ReqTick) &&
                        (prescale_count == 4'd1) &&
                        (slot_phase == stbl_pkg::PhaseRefresh);

  // Prescaler stays within its reload range
  `ASSERT_ALWAYS(a_presc_range, presc_ok, "prescaler out of range")

  // Slot phase moves only together with a prescaler reload
  `ASSERT_IMPL(a_slot_step, slot_phase != $past(slot_phase), presc_full, "slot moved off wrap")

  // A tick on the last prescaler count in phase zero gives a refresh pulse
  `ASSERT_NEXT(a_refresh, refresh_tick, rsp_valid && led_refresh_pulse, "missing refresh pulse")

endmodule
